FILE: rtl/core/hard_link_seen_table_macros.svh
// Assertion macros for the hard link seen table.
`ifndef HARD_LINK_SEEN_TABLE_MACROS_SVH
`define HARD_LINK_SEEN_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HLST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hlst: same-cycle check failed");
`define HLST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hlst: next-cycle check failed");
`else
`define HLST_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HLST_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/hlst_pkg.sv
// Shared widths, table entry layout and controller/datapath signal groups.
package hlst_pkg;

  localparam int unsigned DEV_W       = 32;
  localparam int unsigned INO_W       = 64;
  localparam int unsigned LINK_W      = 32;
  localparam int unsigned COUNT_OUT_W = 11;

  localparam int unsigned BUCKETS_DEF = 256;
  localparam int unsigned WAYS_DEF    = 4;

  typedef struct packed {
    logic              valid;
    logic [DEV_W-1:0]  device;
    logic [INO_W-1:0]  inode;
    logic [LINK_W-1:0] links_left;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic update;
    logic out_load;
    logic clear_wr;
  } cmd_t;

  typedef struct packed {
    logic hash_done;
    logic clear_last;
    logic stop;
  } sts_t;

endpackage

FILE: rtl/core/hlst_rec_if.sv
// File record channel: valid/ready handshake with device, inode and link count.
interface hlst_rec_if;
  import hlst_pkg::*;

  logic              valid;
  logic              ready;
  logic [DEV_W-1:0]  device_id;
  logic [INO_W-1:0]  inode_number;
  logic [LINK_W-1:0] link_count;

  modport source (output valid, device_id, inode_number, link_count, input ready);
  modport sink (input valid, device_id, inode_number, link_count, output ready);
endinterface

FILE: rtl/core/hlst_res_if.sv
// Result channel: valid/ready handshake with repeat flag, stop flag and entry count.
interface hlst_res_if;
  import hlst_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   is_repeat;
  logic                   tracking_stopped;
  logic [COUNT_OUT_W-1:0] entries_in_use;

  modport source (output valid, is_repeat, tracking_stopped, entries_in_use, input ready);
  modport sink (input valid, is_repeat, tracking_stopped, entries_in_use, output ready);
endinterface

FILE: rtl/core/hard_link_seen_table.sv
// Hard link seen table: set-associative duplicate detection with per-entry link counts.
// Each record passes through the hash, a bucket row read, the compare and update, and the
//   output register; the key is reduced by a byte-serial modulo when the bucket count is not a power of two.
// Only one record is in flight: a new record is accepted only after the previous result has been
//   loaded into the output register, while its bucket row is read, compared and written back.
// Reset: a clearing pass writes every row; no record is accepted meanwhile.
`include "hard_link_seen_table_macros.svh"

module hard_link_seen_table #(
  parameter int unsigned BUCKETS = hlst_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS    = hlst_pkg::WAYS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  hlst_rec_if.sink          rec_i,
  hlst_res_if.source        res_o
);
  import hlst_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;
  logic out_valid;

  hlst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rec_i.valid),
    .out_ready_i (res_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  hlst_datapath #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .device_id_i        (rec_i.device_id),
    .inode_number_i     (rec_i.inode_number),
    .link_count_i       (rec_i.link_count),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .is_repeat_o        (res_o.is_repeat),
    .tracking_stopped_o (res_o.tracking_stopped),
    .entries_in_use_o   (res_o.entries_in_use)
  );

  assign rec_i.ready = in_ready;
  assign res_o.valid = out_valid;

  `HLST_ASSERT_NXT(a_single_word_in_flight, clk_i, rst_ni, cmd.accept, !in_ready)
  `HLST_ASSERT_NXT(a_stop_sticky, clk_i, rst_ni, sts.stop, sts.stop)
  `HLST_ASSERT_IMP(a_update_after_read, clk_i, rst_ni, cmd.update, $past(cmd.rd_en))
  `HLST_ASSERT_IMP(a_no_accept_while_clearing, clk_i, rst_ni, cmd.clear_wr, !in_ready)

endmodule

FILE: rtl/core/hlst_bucket_hash.sv
// Bucket index unit: reduces the 64-bit key modulo the bucket count.
module hlst_bucket_hash #(
  parameter int unsigned BUCKETS = hlst_pkg::BUCKETS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hlst_pkg::INO_W-1:0] key_i,
  output logic [$clog2(BUCKETS)-1:0] bucket_o,
  output logic                       done_o
);
  import hlst_pkg::*;

  localparam int unsigned BUCKET_W = $clog2(BUCKETS);
  localparam bit          IS_POW2  = (BUCKETS & (BUCKETS - 1)) == 0;

  if (IS_POW2) begin : g_mask
    logic [BUCKET_W-1:0] bucket_q;
    logic                done_q;

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        bucket_q <= key_i[BUCKET_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else if (start_i) begin
        done_q <= 1'b1;
      end
    end

    assign bucket_o = bucket_q;
    assign done_o   = done_q;
  end else begin : g_serial
    localparam int unsigned DIGIT_W = 8;
    localparam int unsigned STEPS   = INO_W / DIGIT_W;
    localparam int unsigned STEP_W  = $clog2(STEPS);
    localparam int unsigned RW      = BUCKET_W + 1;
    localparam logic [RW-1:0]     BMOD      = RW'(BUCKETS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    logic [INO_W-1:0]   key_q;
    logic [RW-1:0]      rem_q;
    logic [RW-1:0]      rem_d;
    logic [STEP_W-1:0]  step_q;
    logic               busy_q;
    logic               done_q;
    logic [DIGIT_W-1:0] digit;

    assign digit = key_q[INO_W-1 -: DIGIT_W];

    // Fold one byte per cycle: shift in a bit, subtract the modulus if reached.
    always_comb begin
      rem_d = rem_q;
      for (int k = DIGIT_W - 1; k >= 0; k--) begin
        rem_d = {rem_d[RW-2:0], digit[k]};
        if (rem_d >= BMOD) begin
          rem_d = rem_d - BMOD;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        key_q <= key_i;
        rem_q <= '0;
      end else if (busy_q) begin
        key_q <= {key_q[INO_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        rem_q <= rem_d;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        step_q <= '0;
        busy_q <= 1'b0;
        done_q <= 1'b0;
      end else if (start_i) begin
        step_q <= '0;
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end

    assign bucket_o = rem_q[BUCKET_W-1:0];
    assign done_o   = done_q;
  end

endmodule

FILE: rtl/core/hlst_datapath.sv
// Datapath: key capture, bucket memory, way compare, entry update and result register.
module hlst_datapath #(
  parameter int unsigned BUCKETS = hlst_pkg::BUCKETS_DEF,
  parameter int unsigned WAYS    = hlst_pkg::WAYS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  input  logic [hlst_pkg::DEV_W-1:0]       device_id_i,
  input  logic [hlst_pkg::INO_W-1:0]       inode_number_i,
  input  logic [hlst_pkg::LINK_W-1:0]      link_count_i,
  input  hlst_pkg::cmd_t                   cmd_i,
  output hlst_pkg::sts_t                   sts_o,
  output logic                             is_repeat_o,
  output logic                             tracking_stopped_o,
  output logic [hlst_pkg::COUNT_OUT_W-1:0] entries_in_use_o
);
  import hlst_pkg::*;

  localparam int unsigned BUCKET_W = $clog2(BUCKETS);
  localparam int unsigned CNT_W    = $clog2(BUCKETS * WAYS + 1);

  typedef entry_t [WAYS-1:0] row_t;

  row_t mem_q [BUCKETS];

  logic                   count_all_links_q;
  logic [DEV_W-1:0]       dev_q;
  logic [INO_W-1:0]       ino_q;
  logic [LINK_W-1:0]      links_q;
  logic                   track_q;
  row_t                   row_q;
  logic [BUCKET_W-1:0]    bucket;
  logic                   hash_done;
  logic [BUCKET_W-1:0]    clr_addr_q;
  logic [CNT_W-1:0]       count_q;
  logic [CNT_W-1:0]       count_d;
  logic                   stop_q;
  logic                   stop_d;
  logic                   rep_q;
  logic                   rep_d;
  logic                   out_rep_q;
  logic                   out_stop_q;
  logic [COUNT_OUT_W-1:0] out_cnt_q;

  logic [WAYS-1:0]        hit_vec;
  logic [WAYS-1:0]        free_vec;
  logic [WAYS-1:0]        low_vec;
  logic [WAYS-1:0]        hit_oh;
  logic [WAYS-1:0]        free_oh;
  logic                   hit;
  logic                   have_free;
  logic                   freed;
  row_t                   new_row;
  logic                   upd_wr;
  logic                   wr_en;
  logic [BUCKET_W-1:0]    wr_addr;
  row_t                   wr_row;

  hlst_bucket_hash #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.accept),
    .key_i    (INO_W'(device_id_i) ^ inode_number_i),
    .bucket_o (bucket),
    .done_o   (hash_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_all_links_q <= 1'b0;
    end else if (cfg_we_i) begin
      count_all_links_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      dev_q   <= device_id_i;
      ino_q   <= inode_number_i;
      links_q <= link_count_i;
      track_q <= !count_all_links_q && (link_count_i > LINK_W'(1));
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w]  = row_q[w].valid && (row_q[w].device == dev_q) && (row_q[w].inode == ino_q);
      free_vec[w] = !row_q[w].valid;
      low_vec[w]  = row_q[w].links_left <= LINK_W'(1);
    end
  end

  assign hit_oh    = hit_vec & (~hit_vec + WAYS'(1));
  assign free_oh   = free_vec & (~free_vec + WAYS'(1));
  assign hit       = |hit_vec;
  assign have_free = |free_vec;
  assign freed     = |(hit_oh & low_vec);

  always_comb begin
    new_row = row_q;
    upd_wr  = 1'b0;
    count_d = count_q;
    stop_d  = stop_q;
    rep_d   = rep_q;
    if (cmd_i.update) begin
      rep_d = track_q && hit;
      if (track_q) begin
        if (hit) begin
          upd_wr = 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (hit_oh[w]) begin
              if (low_vec[w]) begin
                new_row[w].valid      = 1'b0;
                new_row[w].links_left = '0;
              end else begin
                new_row[w].links_left = row_q[w].links_left - LINK_W'(1);
              end
            end
          end
          if (freed) begin
            count_d = count_q - CNT_W'(1);
          end
        end else if (!stop_q) begin
          if (have_free) begin
            upd_wr  = 1'b1;
            count_d = count_q + CNT_W'(1);
            for (int w = 0; w < WAYS; w++) begin
              if (free_oh[w]) begin
                new_row[w].valid      = 1'b1;
                new_row[w].device     = dev_q;
                new_row[w].inode      = ino_q;
                new_row[w].links_left = links_q - LINK_W'(1);
              end
            end
          end else begin
            stop_d = 1'b1;
          end
        end
      end
    end
  end

  assign wr_en   = cmd_i.clear_wr || upd_wr;
  assign wr_addr = cmd_i.clear_wr ? clr_addr_q : bucket;
  assign wr_row  = cmd_i.clear_wr ? row_t'('0) : new_row;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_row;
    end
    if (cmd_i.rd_en) begin
      row_q <= mem_q[bucket];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      count_q    <= '0;
      stop_q     <= 1'b0;
    end else begin
      if (cmd_i.clear_wr) begin
        clr_addr_q <= clr_addr_q + BUCKET_W'(1);
      end
      count_q <= count_d;
      stop_q  <= stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rep_q <= rep_d;
    if (cmd_i.out_load) begin
      out_rep_q  <= rep_q;
      out_stop_q <= stop_q;
      out_cnt_q  <= COUNT_OUT_W'(count_q);
    end
  end

  assign sts_o.hash_done  = hash_done;
  assign sts_o.clear_last = clr_addr_q == BUCKET_W'(BUCKETS - 1);
  assign sts_o.stop       = stop_q;

  assign is_repeat_o        = out_rep_q;
  assign tracking_stopped_o = out_stop_q;
  assign entries_in_use_o   = out_cnt_q;

endmodule

FILE: rtl/core/hlst_ctrl.sv
// Controller: clearing pass after reset, then accept, hash, lookup, update and output.
module hlst_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_ready_i,
  input  hlst_pkg::sts_t sts_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output hlst_pkg::cmd_t cmd_o
);
  import hlst_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_HASH   = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_OUT    = 5'b10000
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   out_valid_q;
  logic   out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_HASH;
        end
      end
      ST_HASH: begin
        if (sts_i.hash_done) begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
